/* rtl/rpt_pkg.sv */
// Shared types and constants of the RADIUS attribute parser.
`default_nettype none

package rpt_pkg;

	// Fixed header size and the EAP message attribute type.
	localparam int unsigned HEADER_BYTES  = 20;
	localparam logic [7:0]  EAP_ATTR_TYPE = 8'd79;
	localparam logic [7:0]  MIN_ATTR_LEN  = 8'd2;

	// Record queue depth between the parser and the output stage.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Record kinds.
	localparam logic KIND_ATTR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RUNT     = 3'd1;
	localparam logic [2:0] ST_BAD_LEN  = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_LEFTOVER = 3'd4;

	// EAP summary states.
	localparam logic [1:0] EAP_NONE      = 2'd0;
	localparam logic [1:0] EAP_HDR_TRUNC = 2'd1;
	localparam logic [1:0] EAP_HDR_ONLY  = 2'd2;
	localparam logic [1:0] EAP_HDR_TYPE  = 2'd3;

	// EAP codes that carry a type byte.
	localparam logic [7:0] EAP_CODE_REQUEST  = 8'd1;
	localparam logic [7:0] EAP_CODE_RESPONSE = 8'd2;

	// Width of the packed output tdata.
	localparam int unsigned OUT_DATA_W = 72;

	// What one input byte produced: an attribute record, a summary, or both.
	typedef struct packed {
		logic        has_attr;
		logic [7:0]  attr_type;
		logic [7:0]  attr_length;
		logic [2:0]  attr_status;
		logic        has_sum;
		logic [2:0]  sum_status;
		logic        trimmed;
		logic [7:0]  pkt_code;
		logic [7:0]  pkt_identifier;
		logic [15:0] pkt_length;
		logic [1:0]  eap_state;
		logic [7:0]  eap_code;
		logic [7:0]  eap_type;
	} rpt_entry_t;

endpackage

`default_nettype wire

/* rtl/radius_packet_tlv_parser_unit.sv */
// Top level of the RADIUS attribute parser: front end, record queue, output stage.
//
//  channel  | direction | tdata                          | tuser        | tlast
//  s_axis   | in        | data_byte                      | -            | end_of_packet
//  m_axis   | out       | attr_type .. eap_type (72 bit) | record_kind  | last
//
// One byte is accepted per cycle; the parser state updates in that cycle.
// A record passes the record queue and the output stage's hold register before it leaves.
// A byte that yields both an attribute record and a summary sends them one after the
// other; the record queue absorbs this and any downstream stall.
// s_axis_tready is low only while the record queue is full.
// After reset the parser expects the first header byte of a packet.
`default_nettype none

module radius_packet_tlv_parser_unit
	import rpt_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [7:0] attr_type, [15:8] attr_length, [18:16] status, [19] trimmed,
	// [27:20] pkt_code, [35:28] pkt_identifier, [51:36] pkt_length,
	// [53:52] eap_state, [61:54] eap_code, [69:62] eap_type, [71:70] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tuser,  // [0] record_kind
	output logic                       m_axis_tlast
);

	rpt_entry_t front_entry;
	rpt_entry_t queue_entry;
	logic       front_push;
	logic       in_fire;
	logic       q_empty, q_full, q_pop;

	assign s_axis_tready = !q_full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	rpt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_byte (s_axis_tdata),
		.in_eop  (s_axis_tlast),
		.entry   (front_entry),
		.push    (front_push)
	);

	rpt_queue #(
		.WIDTH ($bits(rpt_entry_t)),
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_push),
		.wr_data (front_entry),
		.pop     (q_pop),
		.rd_data (queue_entry),
		.empty   (q_empty),
		.full    (q_full)
	);

	rpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (queue_entry),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

/* rtl/rpt_front.sv */
// Parser front end: walks header and attributes, one accepted byte per cycle.
`default_nettype none

module rpt_front
	import rpt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eop,
	output rpt_entry_t      entry,
	output logic            push
);

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_TYPE   = 5'b00010,
		PH_LEN    = 5'b00100,
		PH_VALUE  = 5'b01000,
		PH_DONE   = 5'b10000
	} rpt_phase_t;

	rpt_phase_t  phase_q, n_phase;
	logic [15:0] byte_count_q, n_byte_count;
	logic [7:0]  code_q, n_code;
	logic [7:0]  ident_q, n_ident;
	logic [15:0] decl_len_q, n_decl_len;
	logic [7:0]  attr_type_q, n_attr_type;
	logic [7:0]  bytes_left_q, n_bytes_left;
	logic [2:0]  status_q, n_status;
	logic [2:0]  eap_cnt_q, n_eap_cnt;
	logic [7:0]  eap_code_q, n_eap_code;
	logic [7:0]  eap_type_q, n_eap_type;
	logic        eap_seen_q, n_eap_seen;

	logic [16:0] pos_p1;
	logic [16:0] len_rem;
	logic [16:0] start_pos;
	logic [16:0] start_rem;
	logic        start_req;
	logic [2:0]  attr_st;
	logic        runt;

	assign pos_p1 = {1'b0, byte_count_q} + 17'd1;
	// Declared bytes left counted from the type byte of this attribute.
	assign len_rem = {1'b0, decl_len_q} - ({1'b0, byte_count_q} - 17'd1);

	// Next-state computation for one byte.
	always_comb begin
		n_phase      = phase_q;
		n_code       = code_q;
		n_ident      = ident_q;
		n_decl_len   = decl_len_q;
		n_attr_type  = attr_type_q;
		n_bytes_left = bytes_left_q;
		n_status     = status_q;
		n_eap_cnt    = eap_cnt_q;
		n_eap_code   = eap_code_q;
		n_eap_type   = eap_type_q;
		n_eap_seen   = eap_seen_q;
		start_req    = 1'b0;
		start_pos    = pos_p1;
		start_rem    = '0;
		attr_st      = ST_OK;
		entry        = '0;

		case (phase_q)
			PH_HEADER: begin
				if (byte_count_q == 16'd0) n_code = in_byte;
				if (byte_count_q == 16'd1) n_ident = in_byte;
				if (byte_count_q == 16'd2) n_decl_len[15:8] = in_byte;
				if (byte_count_q == 16'd3) n_decl_len[7:0] = in_byte;
				if (byte_count_q == 16'(HEADER_BYTES - 1)) begin
					if (decl_len_q < 16'(HEADER_BYTES)) begin
						n_phase = PH_DONE;
					end else begin
						start_req = 1'b1;
						start_pos = 17'(HEADER_BYTES);
					end
				end
			end
			PH_TYPE: begin
				n_attr_type = in_byte;
				n_phase     = PH_LEN;
			end
			PH_LEN: begin
				entry.has_attr    = 1'b1;
				entry.attr_type   = attr_type_q;
				entry.attr_length = in_byte;
				if (in_byte < MIN_ATTR_LEN) begin
					attr_st = ST_BAD_LEN;
					n_phase = PH_DONE;
				end else if (len_rem < {9'd0, in_byte}) begin
					attr_st = ST_TRUNC;
					n_phase = PH_DONE;
				end else begin
					if (attr_type_q == EAP_ATTR_TYPE) n_eap_seen = 1'b1;
					n_bytes_left = in_byte - MIN_ATTR_LEN;
					if (in_byte == MIN_ATTR_LEN) begin
						start_req = 1'b1;
					end else begin
						n_phase = PH_VALUE;
					end
				end
				if (attr_st != ST_OK) n_status = attr_st;
				entry.attr_status = attr_st;
			end
			PH_VALUE: begin
				if (attr_type_q == EAP_ATTR_TYPE) begin
					if (eap_cnt_q == 3'd0) n_eap_code = in_byte;
					if (eap_cnt_q == 3'd4) n_eap_type = in_byte;
					if (eap_cnt_q < 3'd5) n_eap_cnt = eap_cnt_q + 3'd1;
				end
				n_bytes_left = bytes_left_q - 8'd1;
				if (n_bytes_left == 8'd0) start_req = 1'b1;
			end
			default: begin
			end
		endcase

		// Where the next attribute would start: parse it, stop, or flag leftovers.
		if (start_req) begin
			start_rem = {1'b0, decl_len_q} - start_pos;
			if (start_pos >= {1'b0, decl_len_q}) begin
				n_phase = PH_DONE;
			end else if (start_rem <= 17'd2) begin
				n_status = ST_LEFTOVER;
				n_phase  = PH_DONE;
			end else begin
				n_phase = PH_TYPE;
			end
		end

		n_byte_count = (byte_count_q == 16'hFFFF) ? byte_count_q : byte_count_q + 16'd1;

		// End-of-packet summary, built from the state after this byte.
		runt = (n_phase == PH_HEADER) || (n_decl_len < 16'(HEADER_BYTES))
			|| ({1'b0, n_decl_len} > pos_p1);
		entry.has_sum        = in_eop;
		entry.sum_status     = runt ? ST_RUNT : n_status;
		entry.trimmed        = !runt && (byte_count_q >= n_decl_len);
		entry.pkt_code       = n_code;
		entry.pkt_identifier = n_ident;
		entry.pkt_length     = n_decl_len;
		if (!runt && n_eap_seen) begin
			if (n_eap_cnt < 3'd4) begin
				entry.eap_state = EAP_HDR_TRUNC;
			end else begin
				entry.eap_code = n_eap_code;
				if ((n_eap_code == EAP_CODE_REQUEST || n_eap_code == EAP_CODE_RESPONSE)
					&& n_eap_cnt >= 3'd5) begin
					entry.eap_state = EAP_HDR_TYPE;
					entry.eap_type  = n_eap_type;
				end else begin
					entry.eap_state = EAP_HDR_ONLY;
				end
			end
		end
	end

	assign push = in_fire && (entry.has_attr || entry.has_sum);

	// Parser state; everything returns to reset after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			byte_count_q <= '0;
			code_q       <= '0;
			ident_q      <= '0;
			decl_len_q   <= '0;
			attr_type_q  <= '0;
			bytes_left_q <= '0;
			status_q     <= ST_OK;
			eap_cnt_q    <= '0;
			eap_code_q   <= '0;
			eap_type_q   <= '0;
			eap_seen_q   <= 1'b0;
		end else if (in_fire) begin
			if (in_eop) begin
				phase_q      <= PH_HEADER;
				byte_count_q <= '0;
				code_q       <= '0;
				ident_q      <= '0;
				decl_len_q   <= '0;
				attr_type_q  <= '0;
				bytes_left_q <= '0;
				status_q     <= ST_OK;
				eap_cnt_q    <= '0;
				eap_code_q   <= '0;
				eap_type_q   <= '0;
				eap_seen_q   <= 1'b0;
			end else begin
				phase_q      <= n_phase;
				byte_count_q <= n_byte_count;
				code_q       <= n_code;
				ident_q      <= n_ident;
				decl_len_q   <= n_decl_len;
				attr_type_q  <= n_attr_type;
				bytes_left_q <= n_bytes_left;
				status_q     <= n_status;
				eap_cnt_q    <= n_eap_cnt;
				eap_code_q   <= n_eap_code;
				eap_type_q   <= n_eap_type;
				eap_seen_q   <= n_eap_seen;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rpt_queue.sv */
// Small register queue of parser records between front and back.
`default_nettype none

module rpt_queue
	import rpt_pkg::*;
#(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty,
	output logic                  full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rpt_back.sv */
// Output stage: holds one queue entry and sends its one or two records.
`default_nettype none

module rpt_back
	import rpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rpt_entry_t            q_data,
	input  wire logic                  q_empty,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic                       out_kind,
	output logic                       out_last
);

	rpt_entry_t hold_q;
	logic       hold_valid_q;
	logic       attr_sent_q;
	logic       send_attr;
	logic       fire;
	logic       final_rec;

	// The attribute record goes first when an entry carries both.
	assign send_attr = hold_q.has_attr && !attr_sent_q;
	assign final_rec = !(send_attr && hold_q.has_sum);
	assign out_valid = hold_valid_q;
	assign fire      = hold_valid_q && out_ready;
	assign q_pop     = !q_empty && (!hold_valid_q || (fire && final_rec));

	// Pack the current record.
	always_comb begin
		out_data = '0;
		out_last = final_rec;
		if (send_attr) begin
			out_kind        = KIND_ATTR;
			out_data[7:0]   = hold_q.attr_type;
			out_data[15:8]  = hold_q.attr_length;
			out_data[18:16] = hold_q.attr_status;
		end else begin
			out_kind        = KIND_SUMMARY;
			out_data[18:16] = hold_q.sum_status;
			out_data[19]    = hold_q.trimmed;
			out_data[27:20] = hold_q.pkt_code;
			out_data[35:28] = hold_q.pkt_identifier;
			out_data[51:36] = hold_q.pkt_length;
			out_data[53:52] = hold_q.eap_state;
			out_data[61:54] = hold_q.eap_code;
			out_data[69:62] = hold_q.eap_type;
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		if (q_pop) hold_q <= q_data;
	end

	// Hold control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			attr_sent_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				hold_valid_q <= 1'b1;
				attr_sent_q  <= 1'b0;
			end else if (fire) begin
				if (final_rec) begin
					hold_valid_q <= 1'b0;
				end else begin
					attr_sent_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* tb/tlv_record_checker.sv */
// Watches both streams of the RADIUS attribute parser, predicts its records and compares them.
`default_nettype none

module tlv_record_checker
	import rpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
	input  wire logic                  s_axis_tlast,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,  // attr_type .. eap_type, see top level
	input  wire logic                  m_axis_tuser,  // [0] record_kind
	input  wire logic                  m_axis_tlast,
	output int                         failures,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Where the walker stands within the current packet.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TYPE,
		PH_LEN,
		PH_VALUE,
		PH_DONE
	} walk_phase_t;

	// One record as it should leave the block.
	typedef struct packed {
		logic        kind;
		logic [7:0]  attr_type;
		logic [7:0]  attr_length;
		logic [2:0]  status;
		logic        trimmed;
		logic [7:0]  pkt_code;
		logic [7:0]  pkt_identifier;
		logic [15:0] pkt_length;
		logic [1:0]  eap_state;
		logic [7:0]  eap_code;
		logic [7:0]  eap_type;
		logic        last;
	} parse_record_t;

	// Shadow of the parser state.
	logic [15:0] rx_count;
	walk_phase_t phase;
	logic [7:0]  hdr_code;
	logic [7:0]  hdr_ident;
	logic [15:0] decl_len;
	logic [7:0]  cur_type;
	logic [7:0]  value_left;
	logic [2:0]  parse_st;
	int          eap_count;
	logic [7:0]  eap_code_seen;
	logic [7:0]  eap_type_seen;
	logic        eap_seen;

	parse_record_t due_records[$];
	parse_record_t want;

	// Back to the state of a fresh packet.
	task automatic clear_walk();
		rx_count = '0;
		phase = PH_HEADER;
		hdr_code = '0;
		hdr_ident = '0;
		decl_len = '0;
		cur_type = '0;
		value_left = '0;
		parse_st = ST_OK;
		eap_count = 0;
		eap_code_seen = '0;
		eap_type_seen = '0;
		eap_seen = 1'b0;
	endtask

	// Decide what follows once the next attribute would start at next_pos.
	task automatic next_attr(input int next_pos);
		if (next_pos >= int'(decl_len)) begin
			phase = PH_DONE;
		end else if (int'(decl_len) - next_pos <= 2) begin
			parse_st = ST_LEFTOVER;
			phase = PH_DONE;
		end else begin
			phase = PH_TYPE;
		end
	endtask

	// Advance the walker by one payload byte and queue the records it causes.
	task automatic walk_byte(input logic [7:0] b, input logic eop);
		int            pos;
		int            rem;
		logic [2:0]    st;
		logic          runt;
		logic          has_attr;
		parse_record_t attr_rec;
		parse_record_t sum_rec;
		pos = int'(rx_count);
		has_attr = 1'b0;
		attr_rec = '0;
		sum_rec = '0;
		case (phase)
			PH_HEADER: begin
				if (pos == 0) hdr_code = b;
				else if (pos == 1) hdr_ident = b;
				else if (pos == 2) decl_len[15:8] = b;
				else if (pos == 3) decl_len[7:0] = b;
				if (pos == HEADER_BYTES - 1) begin
					if (decl_len < HEADER_BYTES) phase = PH_DONE;
					else next_attr(HEADER_BYTES);
				end
			end
			PH_TYPE: begin
				cur_type = b;
				phase = PH_LEN;
			end
			PH_LEN: begin
				st = ST_OK;
				rem = int'(decl_len) - (pos - 1);
				if (b < MIN_ATTR_LEN) begin
					st = ST_BAD_LEN;
					phase = PH_DONE;
				end else if (rem < int'(b)) begin
					st = ST_TRUNC;
					phase = PH_DONE;
				end else begin
					if (cur_type == EAP_ATTR_TYPE) eap_seen = 1'b1;
					value_left = b - MIN_ATTR_LEN;
					if (value_left == 0) next_attr(pos + 1);
					else phase = PH_VALUE;
				end
				if (st != ST_OK) parse_st = st;
				has_attr = 1'b1;
				attr_rec.kind = KIND_ATTR;
				attr_rec.attr_type = cur_type;
				attr_rec.attr_length = b;
				attr_rec.status = st;
				attr_rec.last = !eop;
			end
			PH_VALUE: begin
				// EAP message bytes run on across all EAP attributes of the packet.
				if (cur_type == EAP_ATTR_TYPE) begin
					if (eap_count == 0) eap_code_seen = b;
					if (eap_count == 4) eap_type_seen = b;
					if (eap_count < 5) eap_count++;
				end
				value_left = value_left - 8'd1;
				if (value_left == 0) next_attr(pos + 1);
			end
			default: begin
			end
		endcase

		if (rx_count != 16'hFFFF) rx_count = rx_count + 16'd1;

		if (has_attr) due_records.push_back(attr_rec);

		// The end of the packet closes it with a summary.
		if (eop) begin
			runt = (phase == PH_HEADER) || (decl_len < HEADER_BYTES) ||
				(int'(decl_len) > pos + 1);
			sum_rec.kind = KIND_SUMMARY;
			sum_rec.status = runt ? ST_RUNT : parse_st;
			sum_rec.trimmed = !runt && (pos >= int'(decl_len));
			sum_rec.pkt_code = hdr_code;
			sum_rec.pkt_identifier = hdr_ident;
			sum_rec.pkt_length = decl_len;
			sum_rec.eap_state = EAP_NONE;
			if (!runt && eap_seen) begin
				if (eap_count < 4) begin
					sum_rec.eap_state = EAP_HDR_TRUNC;
				end else begin
					sum_rec.eap_code = eap_code_seen;
					if ((eap_code_seen == EAP_CODE_REQUEST ||
						eap_code_seen == EAP_CODE_RESPONSE) && eap_count >= 5) begin
						sum_rec.eap_state = EAP_HDR_TYPE;
						sum_rec.eap_type = eap_type_seen;
					end else begin
						sum_rec.eap_state = EAP_HDR_ONLY;
					end
				end
			end
			sum_rec.last = 1'b1;
			due_records.push_back(sum_rec);
			clear_walk();
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want_v,
		input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			failures++;
		end
	endtask

	// Predict on every accepted byte, check every accepted record.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			due_records.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) walk_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_records.size() == 0) begin
					$error("record with none due: tdata %h tuser %b tlast %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					failures++;
				end else begin
					want = due_records.pop_front();
					compare_field("record_kind", want.kind, m_axis_tuser);
					compare_field("attr_type", want.attr_type, m_axis_tdata[7:0]);
					compare_field("attr_length", want.attr_length, m_axis_tdata[15:8]);
					compare_field("status", want.status, m_axis_tdata[18:16]);
					compare_field("trimmed", want.trimmed, m_axis_tdata[19]);
					compare_field("pkt_code", want.pkt_code, m_axis_tdata[27:20]);
					compare_field("pkt_identifier", want.pkt_identifier,
						m_axis_tdata[35:28]);
					compare_field("pkt_length", want.pkt_length, m_axis_tdata[51:36]);
					compare_field("eap_state", want.eap_state, m_axis_tdata[53:52]);
					compare_field("eap_code", want.eap_code, m_axis_tdata[61:54]);
					compare_field("eap_type", want.eap_type, m_axis_tdata[69:62]);
					compare_field("tdata padding", 0, m_axis_tdata[71:70]);
					compare_field("last", want.last, m_axis_tlast);
				end
			end
			outstanding <= due_records.size();
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Top of the parser testbench: clock, reset, packet stimulus, output back-pressure and verdict.
`default_nettype none

module testbench;
	import rpt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no item moving on either side before the run is abandoned.
	localparam int QUIET_LIMIT = 1000;

	// EAP codes that carry no type byte.
	localparam logic [7:0] EAP_CODE_SUCCESS = 8'd3;
	localparam logic [7:0] EAP_CODE_FAILURE = 8'd4;

	// Ways in which a generated packet departs from a clean one.
	typedef enum int {
		PKT_CLEAN,
		PKT_TRAILING,
		PKT_OVERLONG_DECL,
		PKT_SUB_HEADER_DECL,
		PKT_CUT,
		PKT_BAD_ATTR_LEN,
		PKT_OVERRUN_ATTR,
		PKT_LEFTOVER,
		PKT_RANDOM_DECL
	} packet_fault_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	int failures;
	int outstanding;

	logic [7:0] body_bytes[$];
	logic [7:0] frame_bytes[$];
	int         calm_bytes = 0;
	int         stall_left = 0;
	int         steady_left = 0;
	int         quiet_cycles = 0;

	radius_packet_tlv_parser_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	tlv_record_checker record_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Downstream back-pressure, with stretches of steady acceptance.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (steady_left > 0) steady_left--;
			else if ($urandom_range(0, 149) == 0) steady_left = $urandom_range(40, 200);
			else if ($urandom_range(0, 4) == 0) stall_left = gap_len();
		end
	end

	// Abandon the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Offer one byte, after a random gap unless asked not to, and wait for acceptance.
	task automatic send_byte(input logic [7:0] b, input logic eop, input bit no_gaps);
		int gap;
		gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eop;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_frame(input bit no_gaps);
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, no_gaps || calm_bytes > 0);
			if (calm_bytes > 0) calm_bytes--;
		end
	endtask

	// Hold the sender back until every record has left the block.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic add_attr(input logic [7:0] attr_kind, input int vlen);
		body_bytes.push_back(attr_kind);
		body_bytes.push_back(8'(vlen + 2));
		repeat (vlen) body_bytes.push_back(8'($urandom));
	endtask

	// Build one packet in frame_bytes: header, attributes, and perhaps a fault.
	task automatic make_packet();
		logic [7:0]    msg[$];
		logic [7:0]    eap_first;
		logic [15:0]   dl;
		packet_fault_t fault;
		int            i;
		int            n_attr;
		int            eap_slot;
		int            decl;
		int            trail;
		int            cut;
		int            total;
		int            split;
		int            rem;
		body_bytes.delete();
		frame_bytes.delete();
		trail = 0;
		cut = 0;
		fault = PKT_CLEAN;
		n_attr = $urandom_range(0, 4);
		eap_slot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_attr) : -1;
		for (i = 0; i <= n_attr; i++) begin
			if (i == eap_slot) begin
				// An EAP message of random size, sometimes split over two attributes.
				case ($urandom_range(0, 3))
					0: eap_first = EAP_CODE_REQUEST;
					1: eap_first = EAP_CODE_RESPONSE;
					2: eap_first = $urandom_range(0, 1) ? EAP_CODE_SUCCESS : EAP_CODE_FAILURE;
					default: eap_first = 8'($urandom);
				endcase
				total = $urandom_range(0, 8);
				msg.delete();
				for (split = 0; split < total; split++)
					msg.push_back((split == 0) ? eap_first : 8'($urandom));
				split = (total > 1 && $urandom_range(0, 1)) ? $urandom_range(1, total - 1) : total;
				body_bytes.push_back(EAP_ATTR_TYPE);
				body_bytes.push_back(8'(split + 2));
				for (rem = 0; rem < split; rem++) body_bytes.push_back(msg[rem]);
				if (split < total) begin
					body_bytes.push_back(EAP_ATTR_TYPE);
					body_bytes.push_back(8'(total - split + 2));
					for (rem = split; rem < total; rem++) body_bytes.push_back(msg[rem]);
				end
			end
			if (i < n_attr) add_attr(8'($urandom), $urandom_range(0, 6));
		end
		rem = $urandom_range(0, 15);
		if (rem >= 8) fault = packet_fault_t'(rem - 7);
		case (fault)
			PKT_BAD_ATTR_LEN: begin
				body_bytes.push_back(8'($urandom));
				body_bytes.push_back(8'($urandom_range(0, MIN_ATTR_LEN - 1)));
				repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
			end
			PKT_OVERRUN_ATTR: begin
				// The length byte reaches beyond the declared end.
				rem = $urandom_range(2, 6);
				body_bytes.push_back(8'($urandom));
				body_bytes.push_back(8'($urandom_range(rem + 1, 255)));
				repeat (rem - 2) body_bytes.push_back(8'($urandom));
			end
			PKT_LEFTOVER: repeat ($urandom_range(1, 2)) body_bytes.push_back(8'($urandom));
			default: begin
			end
		endcase
		decl = HEADER_BYTES + body_bytes.size();
		case (fault)
			PKT_TRAILING:        trail = $urandom_range(1, 4);
			PKT_OVERLONG_DECL:   decl = decl + $urandom_range(1, 6);
			PKT_SUB_HEADER_DECL: decl = $urandom_range(0, HEADER_BYTES - 1);
			PKT_CUT:             cut = $urandom_range(1, HEADER_BYTES);
			PKT_RANDOM_DECL:     decl = $urandom_range(0, 65535);
			default: begin
			end
		endcase
		dl = 16'(decl);
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(dl[15:8]);
		frame_bytes.push_back(dl[7:0]);
		repeat (HEADER_BYTES - 4) frame_bytes.push_back(8'($urandom));
		for (i = 0; i < body_bytes.size(); i++) frame_bytes.push_back(body_bytes[i]);
		repeat (trail) frame_bytes.push_back(8'($urandom));
		if (cut > 0) begin
			while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
		end
	endtask

	// Reset, a short directed opening, then random packets.
	initial begin
		int sent;
		int i;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A packet of one all-ones byte: ends inside the header.
		frame_bytes.delete();
		frame_bytes.push_back(8'hFF);
		send_frame(1'b0);

		// Zero code, all-ones identifier, then an attribute with a zero length byte.
		frame_bytes.delete();
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'(HEADER_BYTES + 2));
		for (i = 4; i < HEADER_BYTES; i++) frame_bytes.push_back(i[0] ? 8'hFF : 8'h00);
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		send_frame(1'b0);
		drain();

		while (sent < 800) begin
			if ($urandom_range(0, 5) == 0) calm_bytes = $urandom_range(30, 150);
			make_packet();
			send_frame(1'b0);
			sent += frame_bytes.size();
			if ($urandom_range(0, 7) == 0) drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/rpt_pkg.sv
rtl/rpt_front.sv
rtl/rpt_queue.sv
rtl/rpt_back.sv
rtl/radius_packet_tlv_parser_unit.sv
tb/tlv_record_checker.sv
tb/testbench.sv
